/* src/hrm_pkg.sv */
package hrm_pkg;

    // Arithmetic constants of the measurement.
    localparam logic [12:0] SUPPLY_GAIN = 13'd5;
    localparam logic [21:0] RES_FACTOR  = 22'd442;
    localparam logic [9:0]  CURRENT_MIN = 10'd10;
    localparam logic [17:0] RES_OPEN    = 18'd30001;
    localparam logic [1:0]  GROUP_LAST  = 2'd3;

    // Width of the scaled supply times the resistance factor.
    localparam int unsigned PROD_W    = 22;
    // One restoring step per dividend bit.
    localparam logic [4:0]  DIV_STEPS = 5'd22;

    // Status codes of a result word.
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_SUPPLY_LOW = 2'd1;
    localparam logic [1:0] ST_NO_CURRENT = 2'd2;
    localparam logic [1:0] ST_SHORT      = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SUPPLY_MIN     = 2'd0;
    localparam logic [1:0] CFG_RESISTANCE_MIN = 2'd1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic scale;
        logic mul;
        logic div_step;
        logic finish;
    } hrm_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic skip_div;
        logic slot_free;
    } hrm_sts_t;

endpackage

/* src/hrm_ctrl.sv */
module hrm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  hrm_pkg::hrm_sts_t sts,
    output hrm_pkg::hrm_cmd_t cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCALE  = 3'd1;
    localparam logic [2:0] S_MUL    = 3'd2;
    localparam logic [2:0] S_DIV    = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [4:0] cnt_reg;
    logic [4:0] cnt_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCALE;
                end
            end
            S_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul  = 1'b1;
                cnt_next = '0;
                if (sts.skip_div)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == hrm_pkg::DIV_STEPS - 5'd1)
                begin
                    cnt_next   = '0;
                    state_next = S_FINISH;
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            S_FINISH:
            begin
                if (sts.slot_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // At most one datapath command is issued in any cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.scale, cmd.mul, cmd.div_step, cmd.finish}))
        else $error("hrm_ctrl: more than one command at once");

    // The step counter never runs past the last division step.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (cnt_reg < hrm_pkg::DIV_STEPS))
        else $error("hrm_ctrl: division step counter overrun");

    // A measurement that needs the quotient always goes through the divider.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL && !sts.skip_div) |=> (state_reg == S_DIV))
        else $error("hrm_ctrl: division skipped");

endmodule

/* src/hrm_datapath.sv */
module hrm_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    input  logic [1:0]        cfg_index,
    input  logic [14:0]       cfg_data,
    input  logic [9:0]        supply_sample,
    input  logic [9:0]        current_sample,
    input  logic              out_ready,
    input  hrm_pkg::hrm_cmd_t cmd,
    output hrm_pkg::hrm_sts_t sts,
    output logic              out_valid,
    output logic [1:0]        status,
    output logic [12:0]       supply_scaled,
    output logic [17:0]       resistance,
    output logic              average_updated,
    output logic [14:0]       average
);

    logic [12:0] supply_min_reg;
    logic [14:0] resistance_min_reg;

    logic [9:0]  supply_reg;
    logic [9:0]  current_reg;
    logic [12:0] scaled_reg;
    logic [21:0] quo_reg;
    logic [9:0]  rem_reg;

    logic [17:0] last_res_reg;
    logic [17:0] last_res_next;
    logic [16:0] sum_reg;
    logic [16:0] sum_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic [14:0] avg_reg;
    logic [14:0] avg_next;

    logic        out_valid_reg;
    logic [1:0]  out_status_reg;
    logic [12:0] out_scaled_reg;
    logic [17:0] out_res_reg;
    logic        out_upd_reg;
    logic [14:0] out_avg_reg;

    logic        supply_low;
    logic        no_current;
    logic [10:0] trial;
    logic [10:0] diff;
    logic        trial_ge;
    logic [17:0] res_q;
    logic [16:0] sum_add;
    logic [1:0]  status_next;
    logic        upd_next;

    assign supply_low    = (scaled_reg < supply_min_reg);
    assign no_current    = (current_reg < hrm_pkg::CURRENT_MIN);
    assign sts.skip_div  = supply_low || no_current;
    assign sts.slot_free = !out_valid_reg || out_ready;

    // One restoring division step: the next dividend bit enters the remainder.
    assign trial    = {rem_reg, quo_reg[hrm_pkg::PROD_W-1]};
    assign diff     = trial - {1'b0, current_reg};
    assign trial_ge = (trial >= {1'b0, current_reg});

    // The quotient is below 2^18 since the current is at least ten.
    assign res_q   = quo_reg[17:0];
    assign sum_add = sum_reg + res_q[16:0];

    always_comb
    begin
        status_next   = hrm_pkg::ST_OK;
        upd_next      = 1'b0;
        last_res_next = last_res_reg;
        sum_next      = sum_reg;
        count_next    = count_reg;
        avg_next      = avg_reg;
        if (supply_low)
        begin
            status_next = hrm_pkg::ST_SUPPLY_LOW;
        end
        else if (no_current)
        begin
            status_next   = hrm_pkg::ST_NO_CURRENT;
            last_res_next = '0;
        end
        else
        begin
            last_res_next = res_q;
            if (res_q < {3'b000, resistance_min_reg})
            begin
                status_next = hrm_pkg::ST_SHORT;
            end
            else if (res_q >= hrm_pkg::RES_OPEN)
            begin
                status_next = hrm_pkg::ST_NO_CURRENT;
            end
            else if (count_reg == hrm_pkg::GROUP_LAST)
            begin
                avg_next   = sum_add[16:2];
                sum_next   = '0;
                count_next = '0;
                upd_next   = 1'b1;
            end
            else
            begin
                sum_next   = sum_add;
                count_next = count_reg + 2'd1;
            end
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            supply_min_reg     <= 13'd0;
            resistance_min_reg <= 15'd1800;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == hrm_pkg::CFG_SUPPLY_MIN)
            begin
                supply_min_reg <= cfg_data[12:0];
            end
            else if (cfg_index == hrm_pkg::CFG_RESISTANCE_MIN)
            begin
                resistance_min_reg <= cfg_data;
            end
        end
    end

    // Working registers of the current word.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            supply_reg  <= supply_sample;
            current_reg <= current_sample;
        end
        if (cmd.scale)
        begin
            scaled_reg <= 13'(supply_reg) * hrm_pkg::SUPPLY_GAIN;
        end
        if (cmd.mul)
        begin
            quo_reg <= 22'(scaled_reg) * hrm_pkg::RES_FACTOR;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[hrm_pkg::PROD_W-2:0], trial_ge};
            rem_reg <= trial_ge ? diff[9:0] : trial[9:0];
        end
    end

    // Measurement history.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_res_reg <= '0;
            sum_reg      <= '0;
            count_reg    <= '0;
            avg_reg      <= '0;
        end
        else if (cmd.finish)
        begin
            last_res_reg <= last_res_next;
            sum_reg      <= sum_next;
            count_reg    <= count_next;
            avg_reg      <= avg_next;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_status_reg <= status_next;
            out_scaled_reg <= scaled_reg;
            out_res_reg    <= last_res_next;
            out_upd_reg    <= upd_next;
            out_avg_reg    <= avg_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = out_status_reg;
    assign supply_scaled   = out_scaled_reg;
    assign resistance      = out_res_reg;
    assign average_updated = out_upd_reg;
    assign average         = out_avg_reg;

    // A result is never written over one that the receiver has not yet taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid_reg || out_ready))
        else $error("hrm_datapath: result overwritten");

    // A completed group only comes from an accepted, in-range measurement.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && upd_next) |-> (status_next == hrm_pkg::ST_OK))
        else $error("hrm_datapath: average updated on a rejected measurement");

    // The group counter wraps to zero exactly when the average is refreshed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && upd_next) |=> (count_reg == 2'd0 && sum_reg == 17'd0))
        else $error("hrm_datapath: group not restarted after average");

endmodule

/* src/heater_resistance_monitor_top.sv */
// Heater resistance monitor.
// Input channel (in_valid/in_ready) carries one word per measurement: a raw
// supply sample and a raw heater current sample. Output channel
// (out_valid/out_ready) returns exactly one result word per input word:
// status, scaled supply, stored resistance in milliohms, a flag marking a
// completed group of four valid readings, and the latest group average.
// The configuration channel (cfg_valid/cfg_ready) writes supply_min at
// index 0 and resistance_min at index 1; it is always ready and should only
// be used while no measurement is in flight.
// A word needing the division passes from acceptance to out_valid through
// scale, multiply, 22 divider steps and finish; a word rejected for low
// supply or no current skips the divider. One word is in work at a time,
// so a new word is accepted only after the last one finishes, paced by the
// bit-serial restoring divider that yields one quotient bit a cycle.
// Reset clears the configuration to its defaults (supply_min 0,
// resistance_min 1800 milliohms) and the stored resistance, sum, group
// count and average to zero. The result sits in an output register, so a
// new word is accepted while a finished one waits; if the receiver stalls,
// the next word waits at its last step until the register is free.
module heater_resistance_monitor_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [9:0]  supply_sample,
    input  logic [9:0]  current_sample,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [12:0] supply_scaled,
    output logic [17:0] resistance,
    output logic        average_updated,
    output logic [14:0] average,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [14:0] cfg_data
);

    hrm_pkg::hrm_cmd_t cmd;
    hrm_pkg::hrm_sts_t sts;

    // Configuration writes are taken in any cycle.
    assign cfg_ready = 1'b1;

    // The controller sequences one word at a time through the datapath.
    hrm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath holds configuration, history, the divider and the output
    // register.
    hrm_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .supply_sample   (supply_sample),
        .current_sample  (current_sample),
        .out_ready       (out_ready),
        .cmd             (cmd),
        .sts             (sts),
        .out_valid       (out_valid),
        .status          (status),
        .supply_scaled   (supply_scaled),
        .resistance      (resistance),
        .average_updated (average_updated),
        .average         (average)
    );

endmodule
